FILE: src/dpt_pkg.sv
// Package: constants and the witness table for the primality tester.
package dpt_pkg;

  localparam int unsigned NW = 63;
  localparam int unsigned SW = 6;
  localparam int unsigned WIW = 3;

  localparam logic [NW-1:0] SMALL_LIMIT = NW'(64'd4759123141);
  localparam logic [WIW-1:0] SMALL_COUNT = WIW'(3);
  localparam logic [WIW-1:0] LARGE_COUNT = WIW'(7);

  function automatic logic [NW-1:0] witness(input logic big_set, input logic [WIW-1:0] idx);
    logic [NW-1:0] w;
    w = NW'(2);
    if (big_set) begin
      unique case (idx)
        3'd0: w = NW'(2);
        3'd1: w = NW'(325);
        3'd2: w = NW'(9375);
        3'd3: w = NW'(28178);
        3'd4: w = NW'(450775);
        3'd5: w = NW'(9780504);
        3'd6: w = NW'(1795265022);
        default: w = NW'(2);
      endcase
    end else begin
      unique case (idx)
        3'd0: w = NW'(2);
        3'd1: w = NW'(7);
        3'd2: w = NW'(61);
        default: w = NW'(2);
      endcase
    end
    return w;
  endfunction

endpackage

FILE: src/dpt_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add.
module dpt_mulmod (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [dpt_pkg::NW-1:0]  op_x,
  input  logic [dpt_pkg::NW-1:0]  op_y,
  input  logic [dpt_pkg::NW-1:0]  modulus,
  output logic                    busy,
  output logic                    done,
  output logic [dpt_pkg::NW-1:0]  product
);

  logic [dpt_pkg::NW-1:0] acc;
  logic [dpt_pkg::NW-1:0] xs;
  logic [dpt_pkg::NW-1:0] ys;
  logic [dpt_pkg::NW:0]   acc_sum;
  logic [dpt_pkg::NW:0]   dbl_sum;
  logic [dpt_pkg::NW-1:0] acc_next;
  logic [dpt_pkg::NW-1:0] xs_next;

  assign acc_sum = {1'b0, acc} + {1'b0, xs};
  assign dbl_sum = {xs, 1'b0};

  always_comb begin
    acc_next = acc;
    if (ys[0]) begin
      acc_next = (acc_sum >= {1'b0, modulus}) ? dpt_pkg::NW'(acc_sum - {1'b0, modulus})
                                              : acc_sum[dpt_pkg::NW-1:0];
    end
    xs_next = (dbl_sum >= {1'b0, modulus}) ? dpt_pkg::NW'(dbl_sum - {1'b0, modulus})
                                           : dbl_sum[dpt_pkg::NW-1:0];
  end

  assign done    = busy && (ys == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
    if (start) begin
      acc <= '0;
      xs  <= op_x;
      ys  <= op_y;
    end else if (busy && !done) begin
      acc <= acc_next;
      xs  <= xs_next;
      ys  <= {1'b0, ys[dpt_pkg::NW-1:1]};
    end
  end

endmodule

FILE: src/deterministic_primality_test.sv
// Top level: deterministic Miller-Rabin primality test of a 63-bit value.
//
//   channel  | handshake            | payload
//   input    | in_valid / in_ready  | candidate [62:0]
//   output   | out_valid / out_ready| is_prime
//
// One item at a time. Modular products are formed in the bit-serial multiplier;
// a witness needs at most 124 products in all (a^d and the s-1 squarings), and
// an odd candidate is tried against up to 7 witnesses; trivial cases go from
// S_CHECK straight to S_OUT.
// Reset clears the sequencer and the output valid; no clearing pass.
// A result waiting on out_ready stalls the next result in S_OUT only.
module deterministic_primality_test (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [dpt_pkg::NW-1:0] candidate,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_prime
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_WIT   = 4'd3;
  localparam logic [3:0] S_POW   = 4'd4;
  localparam logic [3:0] S_MULR  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_CHK1  = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_SQW   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]                state;
  logic [dpt_pkg::NW-1:0]    n;
  logic [dpt_pkg::NW-1:0]    nm1;
  logic [dpt_pkg::NW-1:0]    d;
  logic [dpt_pkg::SW-1:0]    s;
  logic [dpt_pkg::SW-1:0]    cnt;
  logic [dpt_pkg::NW-1:0]    r;
  logic [dpt_pkg::NW-1:0]    b;
  logic [dpt_pkg::NW-1:0]    e;
  logic [dpt_pkg::WIW-1:0]   wi;
  logic                      big_set;
  logic                      verdict;

  logic                      mm_start;
  logic [dpt_pkg::NW-1:0]    mm_x;
  logic [dpt_pkg::NW-1:0]    mm_y;
  logic                      mm_busy;
  logic                      mm_done;
  logic [dpt_pkg::NW-1:0]    mm_p;
  logic [dpt_pkg::NW-1:0]    wit_a;
  logic [dpt_pkg::WIW-1:0]   wit_count;

  assign in_ready  = (state == S_IDLE);
  assign wit_a     = dpt_pkg::witness(big_set, wi);
  assign wit_count = big_set ? dpt_pkg::LARGE_COUNT : dpt_pkg::SMALL_COUNT;

  always_comb begin
    mm_start = 1'b0;
    mm_x     = b;
    mm_y     = b;
    unique case (state)
      S_POW: begin
        if (e != '0) begin
          mm_start = 1'b1;
          if (e[0]) begin
            mm_x = r;
          end
        end
      end
      S_MULR: begin
        mm_start = mm_done;
      end
      S_SQ: begin
        mm_x = r;
        mm_y = r;
        mm_start = (cnt < s);
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  dpt_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .op_x    (mm_x),
    .op_y    (mm_y),
    .modulus (n),
    .busy    (mm_busy),
    .done    (mm_done),
    .product (mm_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= candidate;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          nm1 <= n - dpt_pkg::NW'(1);
          d   <= n - dpt_pkg::NW'(1);
          s   <= '0;
          big_set <= (n >= dpt_pkg::SMALL_LIMIT);
          wi  <= '0;
          priority if (n <= dpt_pkg::NW'(1)) begin
            verdict <= 1'b0;
            state   <= S_OUT;
          end else if (n == dpt_pkg::NW'(2) || n == dpt_pkg::NW'(7) ||
                       n == dpt_pkg::NW'(61)) begin
            verdict <= 1'b1;
            state   <= S_OUT;
          end else if (!n[0]) begin
            verdict <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (!d[0]) begin
            d <= {1'b0, d[dpt_pkg::NW-1:1]};
            s <= s + dpt_pkg::SW'(1);
          end else begin
            state <= S_WIT;
          end
        end
        S_WIT: begin
          if (wi == wit_count || wit_a >= n) begin
            verdict <= 1'b1;
            state   <= S_OUT;
          end else begin
            r     <= dpt_pkg::NW'(1);
            b     <= wit_a;
            e     <= d;
            state <= S_POW;
          end
        end
        S_POW: begin
          if (e == '0) begin
            state <= S_CHK1;
          end else if (e[0]) begin
            state <= S_MULR;
          end else begin
            state <= S_MULB;
          end
        end
        S_MULR: begin
          if (mm_done) begin
            r     <= mm_p;
            state <= S_MULB;
          end
        end
        S_MULB: begin
          if (mm_done && !mm_start) begin
            b     <= mm_p;
            e     <= {1'b0, e[dpt_pkg::NW-1:1]};
            state <= S_POW;
          end
        end
        S_CHK1: begin
          if (r == dpt_pkg::NW'(1) || r == nm1) begin
            wi    <= wi + dpt_pkg::WIW'(1);
            state <= S_WIT;
          end else begin
            cnt   <= dpt_pkg::SW'(1);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt < s) begin
            state <= S_SQW;
          end else begin
            verdict <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_SQW: begin
          if (mm_done) begin
            r   <= mm_p;
            cnt <= cnt + dpt_pkg::SW'(1);
            priority if (mm_p == dpt_pkg::NW'(1)) begin
              verdict <= 1'b0;
              state   <= S_OUT;
            end else if (mm_p == nm1) begin
              wi    <= wi + dpt_pkg::WIW'(1);
              state <= S_WIT;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            is_prime  <= verdict;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mm_busy)
    else $error("multiplier busy while idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> (!mm_busy || mm_done))
    else $error("multiplier restarted mid-product");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_MULR || state == S_MULB || state == S_SQW))
    else $error("product finished outside a wait state");

  a_odd_modulus: assert property (@(posedge clk) disable iff (rst)
    state == S_POW |-> n[0])
    else $error("modular power on even modulus");

endmodule
